@@ hdl/wmed_pkg.sv @@
// Shared types and constants for the weighted 3x3 RGB median filter.
// No dependencies; imported by the median datapath, the top level and the bench.
package wmed_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned CHANNELS  = 3;
    localparam int unsigned PIX_W     = CH_W * CHANNELS;
    localparam int unsigned WT_W      = 4;
    localparam int unsigned TAPS      = 9;
    localparam int unsigned PROD_W    = CH_W + WT_W;
    localparam int unsigned WIDTH_W   = 11;
    localparam int unsigned HEIGHT_W  = 16;
    localparam int unsigned WEIGHTS_W = WT_W * TAPS;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WIDTH_W-1:0]   WIDTH_RST   = 11'd640;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = 16'd480;
    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RST = 36'h111111111;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_WEIGHTS = 2'd2
    } t_cfg_idx;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [PROD_W-1:0] t_prod;

    // Load enables of the three stages inside the median datapath.
    typedef struct packed {
        logic prd;
        logic srt;
        logic res;
    } t_stage_en;

endpackage

@@ hdl/wmed_median.sv @@
// Weighted median datapath: products, per-row sort, median of nine.
// Depends on wmed_pkg; instantiated by weighted_median_3x3_rgb_unit.
module wmed_median import wmed_pkg::*; (
    input  logic                 i_clk,
    input  t_stage_en            i_en,
    input  t_pixel               i_win [TAPS],
    input  logic [WEIGHTS_W-1:0] i_weights,
    output t_pixel               o_result   // blue [7:0], green [15:8], red [23:16]
);

    t_prod r_prod [CHANNELS][TAPS];
    t_prod r_lo   [CHANNELS][3];
    t_prod r_mid  [CHANNELS][3];
    t_prod r_hi   [CHANNELS][3];
    t_pixel r_result;

    function automatic t_prod min2(input t_prod a, input t_prod b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_prod max2(input t_prod a, input t_prod b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_prod med3(input t_prod a, input t_prod b, input t_prod c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en.prd) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int k = 0; k < TAPS; k++) begin
                    r_prod[ch][k] <= t_prod'(i_win[k][ch*CH_W +: CH_W])
                                   * t_prod'(i_weights[k*WT_W +: WT_W]);
                end
            end
        end
    end

    // Each row of three is sorted; the median of nine is then the median of
    // the largest low, the middle mid and the smallest high.
    always_ff @(posedge i_clk) begin
        if (i_en.srt) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int row = 0; row < 3; row++) begin
                    r_lo[ch][row]  <= min2(min2(r_prod[ch][row*3], r_prod[ch][row*3+1]),
                                           r_prod[ch][row*3+2]);
                    r_mid[ch][row] <= med3(r_prod[ch][row*3], r_prod[ch][row*3+1],
                                           r_prod[ch][row*3+2]);
                    r_hi[ch][row]  <= max2(max2(r_prod[ch][row*3], r_prod[ch][row*3+1]),
                                           r_prod[ch][row*3+2]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_prod m;
        if (i_en.res) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                m = med3(max2(max2(r_lo[ch][0], r_lo[ch][1]), r_lo[ch][2]),
                         med3(r_mid[ch][0], r_mid[ch][1], r_mid[ch][2]),
                         min2(min2(r_hi[ch][0], r_hi[ch][1]), r_hi[ch][2]));
                r_result[ch*CH_W +: CH_W] <= m[CH_W-1:0];
            end
        end
    end

    assign o_result = r_result;

endmodule

@@ hdl/weighted_median_3x3_rgb_unit.sv @@
// Weighted 3x3 median filter on an RGB raster stream, top level.
// An input beat that completes its window passes the first, window, product and sort
// stages to the result stage. Throughput one pixel per cycle unless the output stalls,
// as every one of the 5 pipe stages and the line stores (one read and one write per cycle)
// move a beat each cycle. Border pixels give no result beat. Reset (synchronous, active low) empties the
// pipe, clears the row and column counters and loads the default size and weights.
// Depends on wmed_pkg and wmed_median.
module weighted_median_3x3_rgb_unit import wmed_pkg::*; #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // blue_in [7:0], green_in [15:8], red_in [23:16]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [PIX_W-1:0]     o_m_tdata,   // blue_out [7:0], green_out [15:8], red_out [23:16]
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHTS_W-1:0] i_cfg_data
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [WIDTH_W-1:0]   r_image_width;
    logic [HEIGHT_W-1:0]  r_image_height;
    logic [WEIGHTS_W-1:0] r_mask_weights;

    t_pixel r_line_a [MAX_WIDTH];
    t_pixel r_line_b [MAX_WIDTH];

    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [COL_W-1:0]    last_col;
    logic [HEIGHT_W-1:0] last_row;
    logic                row_end;
    logic                frame_end;
    logic [COL_W-1:0]    n_col;
    logic [HEIGHT_W-1:0] n_row;

    logic             r_s1_vld, r_s1_emit, r_s1_last;
    logic [COL_W-1:0] r_s1_idx;
    t_pixel           r_s1_pix, r_s1_above, r_s1_above2;

    t_pixel r_win [TAPS];
    logic   r_win_vld, r_win_last;
    logic   r_prd_vld, r_prd_last;
    logic   r_srt_vld, r_srt_last;
    logic   r_out_vld, r_out_last;

    logic rdy_s1, rdy_win, rdy_prd, rdy_srt, rdy_out;
    logic ld_s1, ld_win;
    t_stage_en stage_en;
    t_pixel    result;

    // Configuration.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_mask_weights <= WEIGHTS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:   r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:  r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_WEIGHTS: r_mask_weights <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective row and frame bounds, clamped to the supported range.
    always_comb begin
        if (r_image_width < 11'd3) begin
            last_col = COL_W'(2);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(r_image_width - 11'd1);
        end
        last_row = (r_image_height < 16'd3) ? 16'd2 : (r_image_height - 16'd1);
    end

    assign row_end   = (r_col >= last_col);
    assign frame_end = row_end && (r_row >= last_row);

    always_comb begin
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : (r_row + 16'd1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    // Pipeline flow: each stage takes a beat when it is empty or its content moves on.
    assign rdy_out = !r_out_vld || i_m_tready;
    assign rdy_srt = !r_srt_vld || rdy_out;
    assign rdy_prd = !r_prd_vld || rdy_srt;
    assign rdy_win = !r_win_vld || rdy_prd;
    assign rdy_s1  = !r_s1_vld  || rdy_win;

    assign o_s_tready   = rdy_s1;
    assign ld_s1        = i_s_tvalid && rdy_s1;
    assign ld_win       = r_s1_vld && rdy_win;
    assign stage_en.prd = r_win_vld && rdy_prd;
    assign stage_en.srt = r_prd_vld && rdy_srt;
    assign stage_en.res = r_srt_vld && rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_win_vld <= 1'b0;
            r_prd_vld <= 1'b0;
            r_srt_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (ld_s1) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (rdy_s1)  r_s1_vld  <= i_s_tvalid;
            if (rdy_win) r_win_vld <= r_s1_vld && r_s1_emit;
            if (rdy_prd) r_prd_vld <= r_win_vld;
            if (rdy_srt) r_srt_vld <= r_prd_vld;
            if (rdy_out) r_out_vld <= r_srt_vld;
        end
    end

    // Line stores: read when a pixel is taken, written back as it leaves the
    // first stage. A later read of the same column is at least three beats away.
    always_ff @(posedge i_clk) begin
        if (ld_s1) begin
            r_s1_above  <= r_line_a[r_col];
            r_s1_above2 <= r_line_b[r_col];
        end
        if (ld_win) begin
            r_line_a[r_s1_idx] <= r_s1_pix;
            r_line_b[r_s1_idx] <= r_s1_above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s1) begin
            r_s1_pix  <= i_s_tdata;
            r_s1_idx  <= r_col;
            r_s1_emit <= (r_row >= 16'd2) && (r_col >= COL_W'(2));
            r_s1_last <= frame_end;
        end
        if (ld_win) begin
            for (int row = 0; row < 3; row++) begin
                r_win[row*3]   <= r_win[row*3+1];
                r_win[row*3+1] <= r_win[row*3+2];
            end
            r_win[2]   <= r_s1_above2;
            r_win[5]   <= r_s1_above;
            r_win[8]   <= r_s1_pix;
            r_win_last <= r_s1_last;
        end
        if (stage_en.prd) r_prd_last <= r_win_last;
        if (stage_en.srt) r_srt_last <= r_prd_last;
        if (stage_en.res) r_out_last <= r_srt_last;
    end

    wmed_median u_median (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_win     (r_win),
        .i_weights (r_mask_weights),
        .o_result  (result)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = result;
    assign o_m_tlast  = r_out_last;

endmodule

@@ hdl/wmed_checker.sv @@
// Port-level checks for the weighted 3x3 RGB median filter, bound to its top level.
// Depends on wmed_pkg and weighted_median_3x3_rgb_unit.
module wmed_checker import wmed_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [PIX_W-1:0] o_m_tdata,
    input logic             o_m_tlast
);

    // A result beat that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // When the output side can move, nothing inside the pipe blocks the input.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input not ready although the output side is free");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Immediately after reset the input side takes beats.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

endmodule

bind weighted_median_3x3_rgb_unit wmed_checker u_wmed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

@@ bench/weighted_median_3x3_rgb_unit_tb.sv @@
// Self-checking bench for the weighted 3x3 RGB median filter top level.
// Streams frames of random pixels through the unit with random stalls on both sides and
// checks every result beat against an in-bench model. Depends on wmed_pkg and the RTL.
module weighted_median_3x3_rgb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmed_pkg::*;

    localparam int unsigned MAX_W      = 1024;
    localparam int unsigned CYCLE_CAP  = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned HOLD_AT    = 1060;
    localparam int unsigned RAND_ITEMS = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } t_median_px;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [PIX_W-1:0]     i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [PIX_W-1:0]     o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WEIGHTS_W-1:0] i_cfg_data = '0;

    // Shadow of the filter: sizes, weights, line stores, window and raster position.
    logic [WIDTH_W-1:0]   cfg_width = WIDTH_RST;
    logic [HEIGHT_W-1:0]  cfg_height = HEIGHT_RST;
    logic [WEIGHTS_W-1:0] cfg_weights = WEIGHTS_RST;
    t_pixel               line_a [MAX_W];
    t_pixel               line_b [MAX_W];
    t_pixel               win_px [TAPS];
    int unsigned          col_cnt = 0;
    int unsigned          row_cnt = 0;

    t_pixel      pix_q [$];
    t_median_px  median_q [$];
    t_median_px  exp_px;
    int unsigned in_count = 0;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        calm = 1'b0;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    t_pixel edge_px [9] = '{24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55, 24'h800001,
                            24'h7FFFFE, 24'hFFFFFF, 24'h000000, 24'h0F0F0F};

    weighted_median_3x3_rgb_unit #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [WEIGHTS_W-1:0] rand36();
        return WEIGHTS_W'({$urandom(), $urandom()});
    endfunction

    // Channels are biased toward 0 and 255 so that ties in the sort show up often.
    function automatic t_pixel rand_pixel();
        t_pixel px;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            case ($urandom_range(0, 7))
                0:       px[ch*CH_W +: CH_W] = 8'h00;
                1:       px[ch*CH_W +: CH_W] = 8'hFF;
                default: px[ch*CH_W +: CH_W] = 8'($urandom());
            endcase
        end
        return px;
    endfunction

    function automatic int unsigned eff_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_W) return MAX_W;
        return int'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 3) ? 3 : int'(cfg_height);
    endfunction

    // Fifth smallest of the nine weighted taps of one channel, cut to a byte.
    function automatic logic [CH_W-1:0] weighted_mid(input int ch);
        t_prod prods [TAPS];
        t_prod p;
        int    j;
        for (int k = 0; k < TAPS; k++) begin
            p = t_prod'(win_px[k][ch*CH_W +: CH_W]) * t_prod'(cfg_weights[k*WT_W +: WT_W]);
            j = k;
            while (j > 0 && prods[j-1] > p) begin
                prods[j] = prods[j-1];
                j--;
            end
            prods[j] = p;
        end
        return prods[TAPS/2][CH_W-1:0];
    endfunction

    task automatic filter_pixel(input t_pixel px);
        int unsigned ew;
        int unsigned eh;
        int unsigned idx;
        t_pixel      up1;
        t_pixel      up2;
        logic        row_end;
        logic        frame_end;
        t_median_px  res;
        ew = eff_width();
        eh = eff_height();
        idx = (col_cnt < MAX_W) ? col_cnt : MAX_W - 1;
        up1 = line_a[idx];
        up2 = line_b[idx];
        row_end = (col_cnt >= ew - 1);
        frame_end = row_end && (row_cnt >= eh - 1);
        for (int y = 0; y < 3; y++) begin
            win_px[3*y]   = win_px[3*y+1];
            win_px[3*y+1] = win_px[3*y+2];
        end
        win_px[2] = up2;
        win_px[5] = up1;
        win_px[8] = px;
        line_b[idx] = up1;
        line_a[idx] = px;
        // Only a center with a full neighbourhood above and to the left gives a beat.
        if (row_cnt >= 2 && col_cnt >= 2) begin
            res.blue  = weighted_mid(0);
            res.green = weighted_mid(1);
            res.red   = weighted_mid(2);
            res.last  = frame_end;
            median_q.push_back(res);
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : ((row_cnt + 1) & 32'hFFFF);
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHTS_W-1:0] value);
        logic [WEIGHTS_W-1:0] data;
        data = value;
        // Bits above a size field must be ignored, so they carry noise.
        if (idx == CFG_WIDTH) data[WEIGHTS_W-1:WIDTH_W] = (WEIGHTS_W-WIDTH_W)'(rand36());
        if (idx == CFG_HEIGHT) data[WEIGHTS_W-1:HEIGHT_W] = (WEIGHTS_W-HEIGHT_W)'(rand36());
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:   cfg_width = data[WIDTH_W-1:0];
            CFG_HEIGHT:  cfg_height = data[HEIGHT_W-1:0];
            CFG_WEIGHTS: cfg_weights = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Waits until every pixel is in and every result is out, then lets the pipe settle.
    task automatic drain();
        while (pix_q.size() != 0 || i_s_tvalid || median_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_pixels(input int unsigned n);
        repeat (n) pix_q.push_back(rand_pixel());
    endtask

    // Pixel source: one beat held until accepted, random gaps between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                filter_pixel(i_s_tdata);
                in_count <= in_count + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap = src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pix_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pix_q.pop_front();
                    if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 12);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long back-pressure stretch, so the pipe fills and the input stalls.
    always @(posedge i_clk) begin
        if (!hold_done && in_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result sink and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (median_q.size() == 0) begin
                    $error("result beat with nothing pending: tdata %h tlast %b",
                           o_m_tdata, o_m_tlast);
                    fail_cnt++;
                end else begin
                    exp_px = median_q.pop_front();
                    if (o_m_tdata[7:0] !== exp_px.blue) begin
                        $error("blue_out: expected %0d, got %0d", exp_px.blue, o_m_tdata[7:0]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[15:8] !== exp_px.green) begin
                        $error("green_out: expected %0d, got %0d", exp_px.green,
                               o_m_tdata[15:8]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[23:16] !== exp_px.red) begin
                        $error("red_out: expected %0d, got %0d", exp_px.red, o_m_tdata[23:16]);
                        fail_cnt++;
                    end
                    if (o_m_tlast !== exp_px.last) begin
                        $error("frame_last: expected %0d, got %0d", exp_px.last, o_m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap = snk_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned          rand_items;
        logic [WEIGHTS_W-1:0] wts;
        for (int i = 0; i < MAX_W; i++) begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        for (int k = 0; k < TAPS; k++) win_px[k] = '0;
        rand_items = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // Smallest frame, sizes below the minimum, default weights, extreme pixels.
        write_reg(CFG_WIDTH, 36'd1);
        write_reg(CFG_HEIGHT, 36'd2);
        foreach (edge_px[i]) pix_q.push_back(edge_px[i]);
        drain();

        // All weights at their maximum, so products overflow the output byte.
        write_reg(CFG_WEIGHTS, '1);
        write_reg(CFG_WIDTH, 36'd3);
        write_reg(CFG_HEIGHT, 36'd3);
        for (int i = 0; i < 9; i++) pix_q.push_back((i % 2 == 0) ? 24'hFFFFFF : 24'h10F080);
        drain();

        // Widest field value, clamped to the line store depth. One full row shows where
        // the clamped row ends; the frame is then finished at the smallest width.
        write_reg(CFG_WIDTH, 36'd2047);
        write_reg(CFG_HEIGHT, 36'd0);
        write_reg(CFG_WEIGHTS, rand36());
        push_pixels(eff_width() + 1);
        drain();
        write_reg(CFG_WIDTH, 36'd3);
        push_pixels(5);
        drain();

        // Tallest frame, cut short by lowering the height in mid-frame. The long
        // back-pressure stretch falls inside this part.
        write_reg(CFG_WIDTH, 36'($urandom_range(3, 6)));
        write_reg(CFG_HEIGHT, 36'hFFFF);
        write_reg(CFG_WEIGHTS, '0);
        write_reg(REG_SPARE, rand36());
        push_pixels(5 * eff_width());
        drain();
        write_reg(CFG_WEIGHTS, rand36());
        push_pixels(15 * eff_width());
        drain();
        write_reg(CFG_HEIGHT, 36'($urandom_range(0, 4)));
        push_pixels(eff_width());

        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= RAND_ITEMS - 250) calm = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
                drain();
                if ($urandom_range(0, 2) == 0) write_reg(CFG_WIDTH, 36'($urandom_range(0, 24)));
                if ($urandom_range(0, 2) == 0) write_reg(CFG_HEIGHT, 36'($urandom_range(0, 8)));
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       wts = '1;
                        1:       wts = '0;
                        default: wts = rand36();
                    endcase
                    write_reg(CFG_WEIGHTS, wts);
                end
            end
            push_pixels(eff_width() * eff_height());
            rand_items += eff_width() * eff_height();
        end

        drain();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
